@@ rtl/assert_macros.svh @@
// Assertion macros shared by the controller and datapath modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: invariant violated");

// Antecedent in any cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ rtl/miq_pkg.sv @@
// Types and constants of the middle insert queue.
package miq_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned OCC_W   = 11;
   localparam int unsigned CODE_W  = 2;
   localparam int unsigned RSP_DATA_W = 48;

   typedef enum logic [CODE_W-1:0] {
      REQ_PUSH   = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_POP    = 2'd2
   } req_code_type;

   typedef enum logic [CODE_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_code_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } cmd_type;

endpackage

@@ rtl/miq_ctrl.sv @@
// Controller of the middle insert queue: request sequencing and response valid.
`include "assert_macros.svh"

module miq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output miq_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_MOVE = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.accept   = 1'b0;
      cmd.commit   = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_MOVE;
            end
         end
         S_MOVE: begin
            // hold until the response register can take the result
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_commit_sets_valid, clock, reset, cmd.commit, rsp_valid_ff)
   `ASSERT_NEXT(a_accept_then_move, clock, reset, cmd.accept, !req_tready)

endmodule

@@ rtl/miq_datapath.sv @@
// Datapath of the middle insert queue: half rings, pointers and response register.
`include "assert_macros.svh"

module miq_datapath #(
   parameter int unsigned CAPACITY = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  miq_pkg::cmd_type                  cmd,
   input  logic [miq_pkg::CODE_W-1:0]        req_type,
   input  logic signed [miq_pkg::WORD_W-1:0] req_value,
   output logic [miq_pkg::CODE_W-1:0]        rsp_status,
   output logic signed [miq_pkg::WORD_W-1:0] rsp_word,
   output logic [miq_pkg::OCC_W-1:0]         rsp_occupancy
);

   localparam int unsigned HALF_DEPTH = (CAPACITY + 1) / 2;
   localparam int unsigned PTR_W = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(HALF_DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;
   localparam int unsigned TOT_W = $clog2(CAPACITY + 1);
   localparam int unsigned W = miq_pkg::WORD_W;

   logic [W-1:0] front_mem [HALF_DEPTH];
   logic [W-1:0] back_mem  [HALF_DEPTH];

   logic [PTR_W-1:0] fs_ff, fs_in, bs_ff, bs_in;
   logic [CNT_W-1:0] fc_ff, fc_in, bc_ff, bc_in;
   logic             move_ff, move_in, src_val_ff, src_val_in, pop_ok_ff, pop_ok_in;
   logic [PTR_W-1:0] fwaddr_ff;
   logic [W-1:0]     val_ff, front_rd_ff, back_rd_ff, move_word;
   logic [miq_pkg::CODE_W-1:0] status_ff, status_in;
   logic [miq_pkg::CODE_W-1:0] rsp_status_ff;
   logic [W-1:0]               rsp_word_ff;
   logic [miq_pkg::OCC_W-1:0]  rsp_occ_ff;

   logic [TOT_W-1:0] total;
   logic             full, empty, bal, bwr_en;
   logic [PTR_W-1:0] fs_inc, bs_inc, bs_dec, back_tail, front_tail, bwr_addr;
   logic [SUM_W-1:0] tail_sum, ftail_sum;

   always_comb begin
      total  = TOT_W'(fc_ff) + TOT_W'(bc_ff);
      full   = total >= TOT_W'(CAPACITY);
      empty  = (fc_ff == '0);
      bal    = (fc_ff == bc_ff);
      fs_inc = (fs_ff == PTR_W'(HALF_DEPTH - 1)) ? '0 : fs_ff + PTR_W'(1);
      bs_inc = (bs_ff == PTR_W'(HALF_DEPTH - 1)) ? '0 : bs_ff + PTR_W'(1);
      bs_dec = (bs_ff == '0) ? PTR_W'(HALF_DEPTH - 1) : bs_ff - PTR_W'(1);
      tail_sum  = SUM_W'(bs_ff) + SUM_W'(bc_ff);
      if (tail_sum >= SUM_W'(HALF_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(HALF_DEPTH);
      end
      ftail_sum = SUM_W'(fs_ff) + SUM_W'(fc_ff);
      if (ftail_sum >= SUM_W'(HALF_DEPTH)) begin
         ftail_sum = ftail_sum - SUM_W'(HALF_DEPTH);
      end
      back_tail  = PTR_W'(tail_sum);
      front_tail = PTR_W'(ftail_sum);

      fs_in = fs_ff;
      fc_in = fc_ff;
      bs_in = bs_ff;
      bc_in = bc_ff;
      move_in    = 1'b0;
      src_val_in = 1'b0;
      pop_ok_in  = 1'b0;
      bwr_en     = 1'b0;
      bwr_addr   = back_tail;
      status_in  = miq_pkg::STAT_DONE;

      unique case (miq_pkg::req_code_type'(req_type))
         miq_pkg::REQ_PUSH: begin
            if (full) begin
               status_in = miq_pkg::STAT_FULL;
            end else begin
               bwr_en = 1'b1;
               if (bal) begin
                  // head of the back half moves across; it is the new word when empty
                  move_in    = 1'b1;
                  src_val_in = (bc_ff == '0);
                  bs_in      = bs_inc;
                  fc_in      = fc_ff + CNT_W'(1);
               end else begin
                  bc_in = bc_ff + CNT_W'(1);
               end
            end
         end
         miq_pkg::REQ_INSERT: begin
            if (full) begin
               status_in = miq_pkg::STAT_FULL;
            end else if (bal) begin
               // new word moves straight across to the front tail; the back half is not written
               move_in    = 1'b1;
               src_val_in = 1'b1;
               fc_in      = fc_ff + CNT_W'(1);
            end else begin
               bwr_en   = 1'b1;
               bwr_addr = bs_dec;
               bs_in    = bs_dec;
               bc_in    = bc_ff + CNT_W'(1);
            end
         end
         miq_pkg::REQ_POP: begin
            if (empty) begin
               status_in = miq_pkg::STAT_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               fs_in     = fs_inc;
               if (bal) begin
                  move_in = 1'b1;
                  bs_in   = bs_inc;
                  bc_in   = bc_ff - CNT_W'(1);
               end else begin
                  fc_in = fc_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign move_word = src_val_ff ? val_ff : back_rd_ff;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         front_rd_ff <= front_mem[fs_ff];
      end
      if (cmd.commit && move_ff) begin
         front_mem[fwaddr_ff] <= move_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         back_rd_ff <= back_mem[bs_ff];
         if (bwr_en) begin
            back_mem[bwr_addr] <= req_value;
         end
      end
   end

   // pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff <= '0;
         fc_ff <= '0;
         bs_ff <= '0;
         bc_ff <= '0;
      end else if (cmd.accept) begin
         fs_ff <= fs_in;
         fc_ff <= fc_in;
         bs_ff <= bs_in;
         bc_ff <= bc_in;
      end
   end

   // per-request payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         move_ff    <= move_in;
         src_val_ff <= src_val_in;
         pop_ok_ff  <= pop_ok_in;
         status_ff  <= status_in;
         fwaddr_ff  <= front_tail;
         val_ff     <= req_value;
      end
      if (cmd.commit) begin
         rsp_status_ff <= status_ff;
         rsp_word_ff   <= pop_ok_ff ? front_rd_ff : '0;
         rsp_occ_ff    <= miq_pkg::OCC_W'(total);
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_word      = rsp_word_ff;
   assign rsp_occupancy = rsp_occ_ff;

   `ASSERT_ALWAYS(a_halves_balanced, clock, reset,
                  (fc_ff == bc_ff) || (fc_ff == bc_ff + CNT_W'(1)))
   `ASSERT_ALWAYS(a_within_capacity, clock, reset, total <= TOT_W'(CAPACITY))
   `ASSERT_NEXT(a_occupancy_matches, clock, reset, cmd.commit,
                rsp_occ_ff == miq_pkg::OCC_W'(TOT_W'(fc_ff) + TOT_W'(bc_ff)))

endmodule

@@ rtl/middle_insert_queue.sv @@
// Top level of the middle insert queue.
//
// A queue of signed 32-bit words driven by a request stream and answered by a
// response stream, one response per request.
// Request channel (req_): tuser carries the request kind (push at back, insert
// at middle, pop front), tdata carries the word to insert (ignored by a pop).
// Response channel (rsp_): tuser carries the status (done, pop on empty, push
// or insert on full); tdata carries the popped word (zero unless a pop succeeded) and
// the occupancy after the request.
// The queue is kept as two ring buffers, front half and back half, so that the
// middle is always the head of the back half; after each request at most one
// word moves from the back half's head to the front half's tail.
// One request at a time: the next is taken only after the last one commits. The
// accepting cycle reads both halves and writes the back half; the move state then
// writes the moved word into the front half's single write port and loads the
// response register. The response is valid in the cycle after that load.
// Stalls: the response register holds a result while rsp_tready is low; the
// next request is still accepted and its result waits in the move state
// until the register frees.
// Reset clears the pointers and counts; the stores need no clearing.
module middle_insert_queue #(
   parameter int unsigned CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [1:0]  req_tuser,  // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [31:0] popped_word, [42:32] occupancy, rest zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   miq_pkg::cmd_type                   cmd;
   logic [miq_pkg::CODE_W-1:0]         rsp_status;
   logic signed [miq_pkg::WORD_W-1:0]  rsp_word;
   logic [miq_pkg::OCC_W-1:0]          rsp_occupancy;

   miq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   miq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_type      (req_tuser),
      .req_value     (req_tdata),
      .rsp_status    (rsp_status),
      .rsp_word      (rsp_word),
      .rsp_occupancy (rsp_occupancy)
   );

   // pack the response: word low, occupancy above, pad with zeros
   assign rsp_tdata = {{(miq_pkg::RSP_DATA_W - miq_pkg::WORD_W - miq_pkg::OCC_W){1'b0}},
                       rsp_occupancy, rsp_word};
   assign rsp_tuser = rsp_status;

endmodule
